>>> sv/lsb_payload_extractor_core_assert.svh
// Assertion macros used by the checker file of the LSB payload extractor.
`ifndef LSB_PAYLOAD_EXTRACTOR_CORE_ASSERT_SVH
`define LSB_PAYLOAD_EXTRACTOR_CORE_ASSERT_SVH

// Check on every clock edge while out of reset.
`define LSBPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset cycles included.
`define LSBPE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

>>> sv/lsbpe_pkg.sv
package lsbpe_pkg;

    // Message layout
    localparam int unsigned IV_BYTES     = 16;
    localparam int unsigned TAG_BYTES    = 16;
    localparam int unsigned HEADER_BYTES = 4;

    localparam int unsigned LEN_W = 32;

    // Section codes carried on the result word
    localparam logic [1:0] SEC_IV   = 2'd0;
    localparam logic [1:0] SEC_TAG  = 2'd1;
    localparam logic [1:0] SEC_DATA = 2'd2;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_IV     = 5'b00010,
        PH_TAG    = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    // One finished byte from the bit assembler
    typedef struct packed {
        logic       done;
        logic [7:0] value;
    } t_byte_evt;

    // One result word
    typedef struct packed {
        logic       incomplete;
        logic [1:0] section;
        logic       byte_valid;
        logic       last;
        logic [7:0] byte_value;
    } t_result;

endpackage

>>> sv/lsbpe_in_reg.sv
module lsbpe_in_reg
    import lsbpe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    input  logic       i_last,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_data,
    output logic       o_last
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;
    logic       r_last;

    // Take a new word whenever the held one is gone or leaves this cycle.
    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

>>> sv/lsbpe_bit_asm.sv
module lsbpe_bit_asm
    import lsbpe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  logic      i_active,
    input  logic      i_lsb,
    input  logic      i_eoi,
    output t_byte_evt o_evt
);

    logic [2:0] r_bit_pos;
    logic [2:0] n_bit_pos;
    logic [7:0] r_asm;
    logic [7:0] n_asm;
    logic [7:0] built;

    assign built = r_asm | (8'(i_lsb) << r_bit_pos);

    always_comb begin
        n_bit_pos = r_bit_pos;
        n_asm     = r_asm;
        if (i_step) begin
            if (i_eoi) begin
                // End of image rearms; a partial byte is dropped.
                n_bit_pos = 3'd0;
                n_asm     = 8'd0;
            end else if (i_active) begin
                if (r_bit_pos == 3'd7) begin
                    n_bit_pos = 3'd0;
                    n_asm     = 8'd0;
                end else begin
                    n_bit_pos = r_bit_pos + 3'd1;
                    n_asm     = built;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_pos <= 3'd0;
            r_asm     <= 8'd0;
        end else begin
            r_bit_pos <= n_bit_pos;
            r_asm     <= n_asm;
        end
    end

    assign o_evt.done  = i_active && (r_bit_pos == 3'd7);
    assign o_evt.value = built;

endmodule

>>> sv/lsbpe_seq.sv
module lsbpe_seq
    import lsbpe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  logic      i_eoi,
    input  t_byte_evt i_evt,
    output logic      o_active,
    output logic      o_emit,
    output t_result   o_res
);

    t_phase             r_phase;
    t_phase             n_phase;
    logic [LEN_W-1:0]   r_count;
    logic [LEN_W-1:0]   n_count;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   n_len;
    logic [LEN_W-1:0]   cnt_inc;
    logic [LEN_W-1:0]   len_shift;
    logic               emit;
    t_result            res;

    // Next non-empty section after the given one.
    function automatic t_phase phase_after(input t_phase from, input logic len_nz);
        t_phase p;
        p = PH_DONE;
        case (from)
            PH_HEADER: begin
                if (IV_BYTES != 0) begin
                    p = PH_IV;
                end else if (TAG_BYTES != 0) begin
                    p = PH_TAG;
                end else if (len_nz) begin
                    p = PH_DATA;
                end
            end
            PH_IV: begin
                if (TAG_BYTES != 0) begin
                    p = PH_TAG;
                end else if (len_nz) begin
                    p = PH_DATA;
                end
            end
            PH_TAG: begin
                if (len_nz) begin
                    p = PH_DATA;
                end
            end
            default: p = PH_DONE;
        endcase
        return p;
    endfunction

    assign cnt_inc   = r_count + LEN_W'(1);
    assign len_shift = {r_len[LEN_W-9:0], i_evt.value};

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_len   = r_len;
        emit    = 1'b0;
        res     = '0;

        if (i_evt.done) begin
            case (r_phase)
                PH_HEADER: begin
                    n_len = len_shift;
                    if (r_count == LEN_W'(HEADER_BYTES - 1)) begin
                        n_count = '0;
                        n_phase = phase_after(PH_HEADER, len_shift != '0);
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                PH_IV: begin
                    emit           = 1'b1;
                    res.byte_valid = 1'b1;
                    res.byte_value = i_evt.value;
                    res.section    = SEC_IV;
                    if (cnt_inc == LEN_W'(IV_BYTES)) begin
                        n_count = '0;
                        n_phase = phase_after(PH_IV, r_len != '0);
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                PH_TAG: begin
                    emit           = 1'b1;
                    res.byte_valid = 1'b1;
                    res.byte_value = i_evt.value;
                    res.section    = SEC_TAG;
                    if (cnt_inc == LEN_W'(TAG_BYTES)) begin
                        n_count = '0;
                        n_phase = phase_after(PH_TAG, r_len != '0);
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                PH_DATA: begin
                    emit           = 1'b1;
                    res.byte_valid = 1'b1;
                    res.byte_value = i_evt.value;
                    res.section    = SEC_DATA;
                    if (cnt_inc == r_len) begin
                        n_count = '0;
                        n_phase = PH_DONE;
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
            res.last = emit && (n_phase == PH_DONE);
        end

        if (i_eoi) begin
            if (n_phase != PH_DONE) begin
                emit           = 1'b1;
                res.incomplete = 1'b1;
                res.last       = 1'b1;
            end
            n_phase = PH_HEADER;
            n_count = '0;
            n_len   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_count <= '0;
            r_len   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_len   <= n_len;
        end
    end

    assign o_active = (r_phase != PH_DONE);
    assign o_emit   = emit;
    assign o_res    = res;

endmodule

>>> sv/lsbpe_out_reg.sv
module lsbpe_out_reg
    import lsbpe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Slot is free when empty or being drained this cycle.
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> sv/lsb_payload_extractor_core.sv
// LSB payload extractor. Feed one image channel byte per word on the slave
// stream, in row, column, channel order, with tlast on the final byte of the
// image. Bit 0 of each byte is kept; every eight kept bits form one byte,
// first bit into bit 0. The first four bytes are a big-endian length; then
// come the IV bytes, the tag bytes and that many data bytes, each sent on the
// master stream with its section code in tuser, the final one with tlast.
// Words after the message are swallowed until end of image, which rearms the
// block. If the image ends first, one word with incomplete and tlast is sent
// (it also carries a byte that finished on that same word). The block takes
// one word per clock with no bubbles while the result slot is free; a result
// is loaded into the result register when its word leaves the input register.
// The throughput is set by the update of the bit, byte and length counters
// between the input and output registers, and follows master-side tready.
// There is no memory and no clearing pass.
module lsb_payload_extractor_core
    import lsbpe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Slave stream: channel bytes
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] channel_byte
    input  logic       s_axis_tlast,  // end_of_image
    // Master stream: recovered bytes
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] byte_value
    output logic [3:0] m_axis_tuser,  // [0] byte_valid, [2:1] section, [3] incomplete
    output logic       m_axis_tlast   // last
);

    logic       in_valid;
    logic [7:0] in_data;
    logic       in_last;
    logic       out_free;
    logic       step;
    logic       active;
    logic       emit;
    t_byte_evt  byte_evt;
    t_result    res;
    t_result    out_res;

    // Input register: holds the word being worked on.
    lsbpe_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_advance (out_free),
        .o_valid   (in_valid),
        .o_data    (in_data),
        .o_last    (in_last)
    );

    // Advance the held word whenever the result slot can take its result,
    // whether or not it produces one.
    assign step = in_valid && out_free;

    // Gather the LSBs into bytes.
    lsbpe_bit_asm u_bit_asm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_active (active),
        .i_lsb    (in_data[0]),
        .i_eoi    (in_last),
        .o_evt    (byte_evt)
    );

    // Walk header, IV, tag and data sections; flag last and incomplete.
    lsbpe_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_eoi    (in_last),
        .i_evt    (byte_evt),
        .o_active (active),
        .o_emit   (emit),
        .o_res    (res)
    );

    // Result register: parts the two streams.
    lsbpe_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && emit),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res)
    );

    assign m_axis_tdata = out_res.byte_value;
    assign m_axis_tuser = {out_res.incomplete, out_res.section, out_res.byte_valid};
    assign m_axis_tlast = out_res.last;

endmodule

>>> sv/lsbpe_checker.sv
`include "lsb_payload_extractor_core_assert.svh"

module lsbpe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [3:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // A stalled result word holds.
    `LSBPE_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result word changed while stalled")

    // Incomplete always closes the message.
    `LSBPE_ASSERT(a_inc_last, m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tlast, "incomplete without last")

    // A word without a byte is an incomplete marker with zero payload.
    `LSBPE_ASSERT(a_empty_word, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[3] && m_axis_tdata == 8'd0 && m_axis_tuser[2:1] == 2'd0, "bad word without byte")

    // Only three section codes exist.
    `LSBPE_ASSERT(a_section, m_axis_tvalid |-> m_axis_tuser[2:1] != 2'd3, "unknown section code")

    // Reset empties the result register.
    `LSBPE_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind lsb_payload_extractor_core lsbpe_checker u_lsbpe_checker (.*);
